// File: src/kmm_pkg.sv
// package: shared types, codes and defaults for the keyed mutex manager
`timescale 1ns / 1ps
`default_nettype none

package kmm_pkg;

   localparam int DEF_NUM_LOCKS = 16;
   localparam int DEF_NUM_PROCS = 16;

   localparam logic [1:0] CMD_INIT    = 2'd0;
   localparam logic [1:0] CMD_ACQUIRE = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BLOCKED = 2'd1;
   localparam logic [1:0] ST_NOLOCK  = 2'd2;
   localparam logic [1:0] ST_WOKEN   = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] lock_key;
      logic [3:0]         lock_index;
      logic [3:0]         requester_pid;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] granted_index;
      logic [3:0] woken_pid;
   } rsp_type;

   typedef enum logic [0:0] {
      FSM_IDLE,
      FSM_EXEC
   } fsm_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_type;

endpackage

`default_nettype wire

// File: src/keyed_mutex_manager_unit.sv
// Keyed mutex manager: a table of up to sixteen mutexes, each with a key, a
// saturating share count, a locked flag and a FIFO of waiting process ids.
// Each request word is accepted in the idle state; in the execute state all
// keys are compared in parallel, the lowest matching or free entry is picked
// and the lock and its wait queue are updated. A result word that is held
// back on the output stretches the execute cycle; a new request is still
// taken while the previous result waits. No clearing pass is needed after
// reset, and requests are accepted from the first cycle out of reset.
`timescale 1ns / 1ps
`default_nettype none

module keyed_mutex_manager_unit #(
   parameter int NUM_LOCKS = kmm_pkg::DEF_NUM_LOCKS,
   parameter int NUM_PROCS = kmm_pkg::DEF_NUM_PROCS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire kmm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output kmm_pkg::rsp_type      rsp_data
);

   kmm_pkg::ctrl_type ctrl;

   kmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   kmm_dp #(
      .NUM_LOCKS (NUM_LOCKS),
      .NUM_PROCS (NUM_PROCS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// File: src/kmm_ctrl.sv
// controller: request capture, execute sequencing and result valid
`timescale 1ns / 1ps
`default_nettype none

module kmm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output kmm_pkg::ctrl_type      ctrl
);

   kmm_pkg::fsm_type state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_blocked;

   assign out_blocked = rsp_valid_ff && rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kmm_pkg::FSM_IDLE: begin
            if (req_valid) state_in = kmm_pkg::FSM_EXEC;
         end
         kmm_pkg::FSM_EXEC: begin
            if (!out_blocked) state_in = kmm_pkg::FSM_IDLE;
         end
         default: state_in = kmm_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      ctrl.capture = 1'b0;
      ctrl.commit  = 1'b0;
      case (state_ff)
         kmm_pkg::FSM_IDLE: begin
            req_stall    = 1'b0;
            ctrl.capture = req_valid;
         end
         kmm_pkg::FSM_EXEC: begin
            ctrl.commit = !out_blocked;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign rsp_valid_in = ctrl.commit || out_blocked;
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kmm_pkg::FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: src/kmm_dp.sv
// datapath: mutex table, key match, wait queues and result register
`timescale 1ns / 1ps
`default_nettype none

module kmm_dp #(
   parameter int NUM_LOCKS = kmm_pkg::DEF_NUM_LOCKS,
   parameter int NUM_PROCS = kmm_pkg::DEF_NUM_PROCS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire kmm_pkg::ctrl_type ctrl,
   input  wire kmm_pkg::req_type  req_data,
   output kmm_pkg::rsp_type       rsp_data
);

   localparam int LOCK_SLOTS = (NUM_LOCKS < 16) ? NUM_LOCKS : 16;
   localparam int PROC_SLOTS = (NUM_PROCS < 16) ? NUM_PROCS : 16;
   localparam int LOCK_W     = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
   localparam int PROC_W     = $clog2(PROC_SLOTS);

   kmm_pkg::req_type req_ff;
   kmm_pkg::rsp_type rsp_ff, rsp_in;

   logic [31:0]       key_ff    [LOCK_SLOTS];
   logic [7:0]        share_ff  [LOCK_SLOTS];
   logic              locked_ff [LOCK_SLOTS];
   logic              qne_ff    [LOCK_SLOTS];
   logic [PROC_W-1:0] head_ff   [LOCK_SLOTS];
   logic [PROC_W-1:0] tail_ff   [LOCK_SLOTS];
   logic [PROC_W-1:0] next_ff   [PROC_SLOTS];

   logic [PROC_W-1:0] pid_mod [16];

   logic [LOCK_SLOTS-1:0] match_vec, free_vec;
   logic [LOCK_W-1:0]     match_idx, free_idx, idx, share_sel;
   logic                  idx_ok;
   logic [PROC_W-1:0]     pid, cur_head, cur_tail;
   logic                  cur_locked, cur_qne;

   logic                  share_we, key_we, lock_we, lock_val, qne_we, qne_val;
   logic                  head_we, tail_we, next_we;
   logic [7:0]            share_val;
   logic [PROC_W-1:0]     head_val;

   for (genvar g = 0; g < 16; g++) begin : g_pid_mod
      assign pid_mod[g] = PROC_W'(g % NUM_PROCS);
   end

   assign idx        = req_ff.lock_index[LOCK_W-1:0];
   assign idx_ok     = ({1'b0, req_ff.lock_index} < 5'(LOCK_SLOTS));
   assign pid        = pid_mod[req_ff.requester_pid];
   assign cur_locked = locked_ff[idx];
   assign cur_qne    = qne_ff[idx];
   assign cur_head   = head_ff[idx];
   assign cur_tail   = tail_ff[idx];

   always_comb begin
      for (int i = 0; i < LOCK_SLOTS; i++) begin
         match_vec[i] = (share_ff[i] != 8'd0) && (key_ff[i] == req_ff.lock_key);
         free_vec[i]  = (share_ff[i] == 8'd0);
      end
   end

   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int i = LOCK_SLOTS - 1; i >= 0; i--) begin
         if (match_vec[i]) match_idx = LOCK_W'(i);
         if (free_vec[i])  free_idx  = LOCK_W'(i);
      end
   end

   always_comb begin
      rsp_in    = '0;
      share_we  = 1'b0;
      share_val = 8'd0;
      share_sel = match_idx;
      key_we    = 1'b0;
      lock_we   = 1'b0;
      lock_val  = 1'b0;
      qne_we    = 1'b0;
      qne_val   = 1'b0;
      head_we   = 1'b0;
      head_val  = pid;
      tail_we   = 1'b0;
      next_we   = 1'b0;
      case (req_ff.cmd)
         kmm_pkg::CMD_INIT: begin
            if (|match_vec) begin
               share_we  = 1'b1;
               share_val = (share_ff[match_idx] == 8'hFF) ? 8'hFF
                                                          : share_ff[match_idx] + 8'd1;
               rsp_in.granted_index = 4'(match_idx);
            end else if (|free_vec) begin
               share_we  = 1'b1;
               share_sel = free_idx;
               share_val = 8'd1;
               key_we    = 1'b1;
               rsp_in.granted_index = 4'(free_idx);
            end else begin
               rsp_in.status = kmm_pkg::ST_NOLOCK;
            end
         end
         kmm_pkg::CMD_ACQUIRE: begin
            if (idx_ok) begin
               if (!cur_locked) begin
                  lock_we  = 1'b1;
                  lock_val = 1'b1;
               end else begin
                  tail_we = 1'b1;
                  if (cur_qne) begin
                     next_we = 1'b1;
                  end else begin
                     head_we = 1'b1;
                     qne_we  = 1'b1;
                     qne_val = 1'b1;
                  end
                  rsp_in.status = kmm_pkg::ST_BLOCKED;
               end
            end
         end
         kmm_pkg::CMD_RELEASE: begin
            if (idx_ok) begin
               if (!cur_qne) begin
                  lock_we = 1'b1;
               end else begin
                  if (cur_head == cur_tail) begin
                     qne_we = 1'b1;
                  end else begin
                     head_we  = 1'b1;
                     head_val = next_ff[cur_head];
                  end
                  rsp_in.status    = kmm_pkg::ST_WOKEN;
                  rsp_in.woken_pid = 4'(cur_head);
               end
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) req_ff <= req_data;
      if (ctrl.commit) begin
         rsp_ff <= rsp_in;
         if (key_we)  key_ff[share_sel] <= req_ff.lock_key;
         if (head_we) head_ff[idx] <= head_val;
         if (tail_we) tail_ff[idx] <= pid;
         if (next_we) next_ff[cur_tail] <= pid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LOCK_SLOTS; i++) begin
            share_ff[i]  <= 8'd0;
            locked_ff[i] <= 1'b0;
            qne_ff[i]    <= 1'b0;
         end
      end else if (ctrl.commit) begin
         if (share_we) share_ff[share_sel] <= share_val;
         if (lock_we)  locked_ff[idx] <= lock_val;
         if (qne_we)   qne_ff[idx] <= qne_val;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// File: tb/tb.sv
// testbench for the keyed mutex manager: directed and random traffic checked against a built-in predictor
`timescale 1ns / 1ps

module tb;

   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int LOCK_SLOTS = 16;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   kmm_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   kmm_pkg::rsp_type rsp_data;

   keyed_mutex_manager_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // shadow copy of the mutex table
   logic signed [31:0] tbl_key    [LOCK_SLOTS];
   logic [7:0]         tbl_share  [LOCK_SLOTS];
   logic               tbl_locked [LOCK_SLOTS];
   logic [3:0]         q_head     [LOCK_SLOTS];
   logic [3:0]         q_tail     [LOCK_SLOTS];
   logic               q_busy     [LOCK_SLOTS];
   logic [3:0]         wait_next  [LOCK_SLOTS];
   logic               wait_next_set [LOCK_SLOTS];

   kmm_pkg::rsp_type owed_replies[$];
   kmm_pkg::rsp_type owed;
   int unsigned      mismatch_count = 0;
   bit               send_idle_on = 1'b0;
   bit               recv_idle_on = 1'b0;
   int unsigned      hold_len = 0;
   int unsigned      hold_cnt = 0;
   int unsigned      burst_left = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("keyed_mutex_manager_unit regression: fail");
      $finish;
   end

   function automatic kmm_pkg::rsp_type predict_mutex(input kmm_pkg::req_type w);
      kmm_pkg::rsp_type r;
      bit               hit;
      int               i;
      logic [3:0]       h;
      r = '0;
      hit = 1'b0;
      case (w.cmd)
         kmm_pkg::CMD_INIT: begin
            for (i = 0; i < LOCK_SLOTS; i++) begin
               if (!hit && tbl_share[i] != 8'd0 && tbl_key[i] == w.lock_key) begin
                  if (tbl_share[i] != 8'd255) tbl_share[i] = tbl_share[i] + 8'd1;
                  r.granted_index = 4'(i);
                  hit = 1'b1;
               end
            end
            for (i = 0; i < LOCK_SLOTS; i++) begin
               if (!hit && tbl_share[i] == 8'd0) begin
                  tbl_share[i] = 8'd1;
                  tbl_key[i] = w.lock_key;
                  r.granted_index = 4'(i);
                  hit = 1'b1;
               end
            end
            if (!hit) r.status = kmm_pkg::ST_NOLOCK;
         end
         kmm_pkg::CMD_ACQUIRE: begin
            if (!tbl_locked[w.lock_index]) begin
               tbl_locked[w.lock_index] = 1'b1;
               r.status = kmm_pkg::ST_OK;
            end else begin
               if (q_busy[w.lock_index]) begin
                  wait_next[q_tail[w.lock_index]] = w.requester_pid;
                  wait_next_set[q_tail[w.lock_index]] = 1'b1;
                  q_tail[w.lock_index] = w.requester_pid;
               end else begin
                  q_head[w.lock_index] = w.requester_pid;
                  q_tail[w.lock_index] = w.requester_pid;
                  q_busy[w.lock_index] = 1'b1;
               end
               r.status = kmm_pkg::ST_BLOCKED;
            end
         end
         kmm_pkg::CMD_RELEASE: begin
            if (!q_busy[w.lock_index]) begin
               tbl_locked[w.lock_index] = 1'b0;
               r.status = kmm_pkg::ST_OK;
            end else begin
               h = q_head[w.lock_index];
               if (h == q_tail[w.lock_index]) q_busy[w.lock_index] = 1'b0;
               else q_head[w.lock_index] = wait_next[h];
               r.status = kmm_pkg::ST_WOKEN;
               r.woken_pid = h;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic kmm_pkg::req_type random_word();
      kmm_pkg::req_type w;
      int               pick;
      int               slot;
      w.lock_key = $urandom;
      w.requester_pid = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) < 7) w.lock_index = 4'($urandom_range(0, 3));
      else w.lock_index = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         w.cmd = kmm_pkg::CMD_INIT;
         if ($urandom_range(0, 9) < 7) begin
            slot = $urandom_range(0, LOCK_SLOTS - 1);
            if (tbl_share[slot] != 8'd0) w.lock_key = tbl_key[slot];
         end
      end else if (pick < 57) begin
         w.cmd = kmm_pkg::CMD_ACQUIRE;
      end else if (pick < 97) begin
         w.cmd = kmm_pkg::CMD_RELEASE;
      end else begin
         w.cmd = CMD_UNKNOWN;
      end
      return w;
   endfunction

   task automatic send_word(input kmm_pkg::req_type w);
      int gap;
      // a handoff must never follow a link that was never written
      if (w.cmd == kmm_pkg::CMD_RELEASE && q_busy[w.lock_index] &&
          q_head[w.lock_index] != q_tail[w.lock_index] &&
          !wait_next_set[q_head[w.lock_index]]) begin
         w.cmd = kmm_pkg::CMD_ACQUIRE;
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      owed_replies.push_back(predict_mutex(w));
      gap = 0;
      if (send_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fields(input logic [1:0] cmd, input logic [31:0] key,
                              input int idx, input int pid);
      kmm_pkg::req_type w;
      w.cmd = cmd;
      w.lock_key = key;
      w.lock_index = 4'(idx);
      w.requester_pid = 4'(pid);
      send_word(w);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_replies.size() != 0) @(posedge clock);
   endtask

   task automatic test_key_allocation();
      int i;
      send_fields(kmm_pkg::CMD_INIT, 32'd5, 0, 0);
      // zero key must not match a free entry
      send_fields(kmm_pkg::CMD_INIT, 32'd0, 15, 15);
      send_fields(kmm_pkg::CMD_INIT, 32'd0, 0, 0);
      send_fields(kmm_pkg::CMD_INIT, 32'h7fff_ffff, 0, 0);
      send_fields(kmm_pkg::CMD_INIT, 32'h8000_0000, 0, 0);
      send_fields(kmm_pkg::CMD_INIT, 32'hffff_ffff, 0, 0);
      for (i = 5; i < LOCK_SLOTS; i++) send_fields(kmm_pkg::CMD_INIT, $urandom, i, i);
      // table full
      send_fields(kmm_pkg::CMD_INIT, 32'h1234_5678, 0, 0);
   endtask

   task automatic test_lock_handoff();
      send_fields(kmm_pkg::CMD_ACQUIRE, 32'hffff_ffff, 3, 0);
      send_fields(kmm_pkg::CMD_ACQUIRE, 32'h0, 3, 15);
      send_fields(kmm_pkg::CMD_ACQUIRE, 32'h0, 3, 7);
      send_fields(kmm_pkg::CMD_RELEASE, 32'h0, 3, 0);
      send_fields(kmm_pkg::CMD_RELEASE, 32'h0, 3, 0);
      send_fields(kmm_pkg::CMD_RELEASE, 32'h0, 3, 0);
      send_fields(kmm_pkg::CMD_RELEASE, 32'h0, 3, 0);
      send_fields(CMD_UNKNOWN, 32'hffff_ffff, 15, 15);
      send_fields(kmm_pkg::CMD_ACQUIRE, 32'h0, 15, 15);
      send_fields(kmm_pkg::CMD_RELEASE, 32'h0, 15, 0);
   endtask

   task automatic test_share_saturation();
      kmm_pkg::req_type w;
      int               i;
      for (i = 0; i < 260; i++) begin
         w = random_word();
         w.cmd = kmm_pkg::CMD_INIT;
         w.lock_key = 32'h7fff_ffff;
         send_word(w);
      end
   endtask

   task automatic test_random_traffic(input int count);
      int i;
      for (i = 0; i < count; i++) send_word(random_word());
   endtask

   task automatic test_backpressure();
      int i;
      send_idle_on = 1'b0;
      hold_len = hold_cnt + 300;
      for (i = 0; i < 40; i++) send_word(random_word());
      drain_results();
      send_idle_on = 1'b1;
   endtask

   // receiver side: random stall bursts plus an optional long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         burst_left <= 0;
      end else if (hold_cnt < hold_len) begin
         rsp_stall <= 1'b1;
         hold_cnt <= hold_cnt + 1;
      end else if (burst_left != 0) begin
         rsp_stall <= 1'b1;
         burst_left <= burst_left - 1;
      end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         burst_left <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (owed_replies.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            $display("%0t: unexpected word, expected none actual %h", $time, rsp_data);
         end else begin
            owed = owed_replies.pop_front();
            if (rsp_data.status !== owed.status) begin
               mismatch_count = mismatch_count + 1;
               $display("%0t: status expected %0d actual %0d",
                        $time, owed.status, rsp_data.status);
            end
            if (rsp_data.granted_index !== owed.granted_index) begin
               mismatch_count = mismatch_count + 1;
               $display("%0t: granted_index expected %0d actual %0d",
                        $time, owed.granted_index, rsp_data.granted_index);
            end
            if (rsp_data.woken_pid !== owed.woken_pid) begin
               mismatch_count = mismatch_count + 1;
               $display("%0t: woken_pid expected %0d actual %0d",
                        $time, owed.woken_pid, rsp_data.woken_pid);
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < LOCK_SLOTS; i++) begin
         tbl_key[i] = '0;
         tbl_share[i] = '0;
         tbl_locked[i] = 1'b0;
         q_head[i] = '0;
         q_tail[i] = '0;
         q_busy[i] = 1'b0;
         wait_next[i] = '0;
         wait_next_set[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      test_key_allocation();
      test_lock_handoff();
      test_share_saturation();
      test_random_traffic(450);
      test_backpressure();
      test_random_traffic(450);
      drain_results();
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      test_random_traffic(200);
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && owed_replies.size() == 0) begin
         $display("keyed_mutex_manager_unit regression: pass");
      end else begin
         $display("keyed_mutex_manager_unit regression: fail");
      end
      $finish;
   end

endmodule
